// ----- rtl/ctp_pkg.sv -----
`default_nettype none
package ctp_pkg;

    localparam int COORD_BITS = 10;
    localparam int FIELD_W    = COORD_BITS;
    localparam int CFG_W      = COORD_BITS;
    localparam int OUT_W      = 12;
    localparam int SQRT_FRAC  = 8;
    localparam int LANES      = 4;

    localparam int CENTER_X_RESET = 400;
    localparam int CENTER_Y_RESET = 300;
    localparam int RADIUS_RESET   = 100;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [FIELD_W-1:0] point_x;
        logic [FIELD_W-1:0] point_y;
    } t_in;

    typedef struct packed {
        logic                    valid_res;
        logic signed [OUT_W-1:0] tan1_x;
        logic signed [OUT_W-1:0] tan1_y;
        logic signed [OUT_W-1:0] tan2_x;
        logic signed [OUT_W-1:0] tan2_y;
    } t_out;

endpackage
`default_nettype wire

// ----- rtl/ctp_sqrt.sv -----
`default_nettype none
module ctp_sqrt #(
    parameter int RAD_W  = 38,
    parameter int SIDE_W = 44
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [RAD_W-1:0]     i_rad,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_valid,
    output logic [RAD_W/2-1:0]        o_root,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int SB  = RAD_W / 2;
    localparam int RMW = SB + 3;

    logic              r_v    [SB];
    logic [RAD_W-1:0]  r_rad  [SB];
    logic [RMW-1:0]    r_rem  [SB];
    logic [SB-1:0]     r_root [SB];
    logic [SIDE_W-1:0] r_side [SB];

    logic              w_v    [SB];
    logic [RAD_W-1:0]  w_rad  [SB];
    logic [RMW-1:0]    w_rem  [SB];
    logic [SB-1:0]     w_root [SB];
    logic [SIDE_W-1:0] w_side [SB];

    // One root bit per stage: two radicand bits enter the partial remainder each step.
    for (genvar k = 0; k < SB; k++) begin : g_stage
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;
        logic [RMW-1:0] n_rem;
        logic [SB-1:0]  n_root;

        if (k == 0) begin : g_first
            assign w_v[k]    = i_valid;
            assign w_rad[k]  = i_rad;
            assign w_rem[k]  = '0;
            assign w_root[k] = '0;
            assign w_side[k] = i_side;
        end else begin : g_next
            assign w_v[k]    = r_v[k-1];
            assign w_rad[k]  = r_rad[k-1];
            assign w_rem[k]  = r_rem[k-1];
            assign w_root[k] = r_root[k-1];
            assign w_side[k] = r_side[k-1];
        end

        always_comb begin
            rem_sh = {w_rem[k][RMW-3:0], w_rad[k][RAD_W-1 -: 2]};
            trial  = {1'b0, w_root[k], 2'b01};
            ge     = rem_sh >= trial;
            n_rem  = ge ? rem_sh - trial : rem_sh;
            n_root = {w_root[k][SB-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {w_rad[k][RAD_W-3:0], 2'b00};
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_v[SB-1];
    assign o_root  = r_root[SB-1];
    assign o_side  = r_side[SB-1];

endmodule
`default_nettype wire

// ----- rtl/ctp_div.sv -----
`default_nettype none
module ctp_div #(
    parameter int MAG_W  = 44,
    parameter int DEN_W  = 29,
    parameter int Q_B    = 12,
    parameter int SIDE_W = 5
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [ctp_pkg::LANES-1:0][MAG_W-1:0]  i_mag,
    input  wire logic [DEN_W-1:0]                      i_den,
    input  wire logic [SIDE_W-1:0]                     i_side,
    output logic                                       o_valid,
    output logic [ctp_pkg::LANES-1:0][Q_B-1:0]         o_quo,
    output logic [SIDE_W-1:0]                          o_side
);

    localparam int CW = (MAG_W > DEN_W + Q_B) ? MAG_W : DEN_W + Q_B;
    localparam int NL = ctp_pkg::LANES;

    logic                      r_v    [Q_B];
    logic [NL-1:0][CW-1:0]     r_rem  [Q_B];
    logic [NL-1:0][Q_B-1:0]    r_quo  [Q_B];
    logic [DEN_W-1:0]          r_den  [Q_B];
    logic [SIDE_W-1:0]         r_side [Q_B];

    logic                      w_v    [Q_B];
    logic [NL-1:0][CW-1:0]     w_rem  [Q_B];
    logic [NL-1:0][Q_B-1:0]    w_quo  [Q_B];
    logic [DEN_W-1:0]          w_den  [Q_B];
    logic [SIDE_W-1:0]         w_side [Q_B];

    // Restoring division, quotient bits from the top down, one bit per stage,
    // all four lanes sharing the divisor.
    for (genvar k = 0; k < Q_B; k++) begin : g_stage
        logic [CW-1:0]          dsh;
        logic [NL-1:0][CW-1:0]  n_rem;
        logic [NL-1:0][Q_B-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_v[k]    = i_valid;
            for (genvar l = 0; l < NL; l++) begin : g_lane
                assign w_rem[k][l] = CW'(i_mag[l]);
            end
            assign w_quo[k]  = '0;
            assign w_den[k]  = i_den;
            assign w_side[k] = i_side;
        end else begin : g_next
            assign w_v[k]    = r_v[k-1];
            assign w_rem[k]  = r_rem[k-1];
            assign w_quo[k]  = r_quo[k-1];
            assign w_den[k]  = r_den[k-1];
            assign w_side[k] = r_side[k-1];
        end

        always_comb begin
            dsh = CW'(w_den[k]) << (Q_B - 1 - k);
            for (int l = 0; l < NL; l++) begin
                if (w_rem[k][l] >= dsh) begin
                    n_rem[l] = w_rem[k][l] - dsh;
                    n_quo[l] = {w_quo[k][l][Q_B-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_rem[k][l];
                    n_quo[l] = {w_quo[k][l][Q_B-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_den[k]  <= w_den[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_v[Q_B-1];
    assign o_quo   = r_quo[Q_B-1];
    assign o_side  = r_side[Q_B-1];

endmodule
`default_nettype wire

// ----- rtl/circle_tangent_points.sv -----
// Throughput: one point per cycle while the output is not stalled; the square root
// (COORD_BITS + 9 stages) and the divider (COORD_BITS + 2 stages) are fully
// pipelined, one result bit per stage.
// A stall at the output freezes every stage together, nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits and loads center (400, 300)
// and radius 100.
`default_nettype none
module circle_tangent_points (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire ctp_pkg::t_in                i_data,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output ctp_pkg::t_out                    o_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [ctp_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int N      = ctp_pkg::COORD_BITS;
    localparam int FR     = ctp_pkg::SQRT_FRAC;
    localparam int NL     = ctp_pkg::LANES;
    localparam int DXW    = N + 1;
    localparam int SQW    = 2 * N;
    localparam int H2W    = 2 * N + 1;
    localparam int RAD_W  = 2 * N + 18;
    localparam int SB     = RAD_W / 2;
    localparam int SIDE_W = 1 + 2 * DXW + H2W;
    localparam int RDW    = 2 * N + 2;
    localparam int SDW    = SB + 1 + DXW;
    localparam int NUMW   = 2 * N + 12;
    localparam int RNW    = N + 1 + NUMW;
    localparam int DENW   = H2W + FR;
    localparam int CDW    = N + DENW;
    localparam int TOTW   = 3 * N + 14;
    localparam int QB     = N + 2;
    localparam int OW     = ctp_pkg::OUT_W;
    localparam int QVW    = (QB + 1 > OW) ? QB + 1 : OW;

    logic en;
    logic r_out_valid;

    logic [N-1:0] r_cx;
    logic [N-1:0] r_cy;
    logic [N-1:0] r_rad;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= N'(ctp_pkg::CENTER_X_RESET);
            r_cy  <= N'(ctp_pkg::CENTER_Y_RESET);
            r_rad <= N'(ctp_pkg::RADIUS_RESET);
        end else if (i_cfg_we) begin
            case (ctp_pkg::t_cfg_idx'(i_cfg_idx))
                ctp_pkg::CFG_CENTER_X: r_cx  <= N'(i_cfg_data);
                ctp_pkg::CFG_CENTER_Y: r_cy  <= N'(i_cfg_data);
                ctp_pkg::CFG_RADIUS:   r_rad <= N'(i_cfg_data);
                default: ;
            endcase
        end
    end

    logic signed [N:0] rad_s;
    assign rad_s = $signed({1'b0, r_rad});

    // Stage 1: offset from the center
    logic                  r1_v;
    logic signed [DXW-1:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= $signed({1'b0, N'(i_data.point_x)}) - $signed({1'b0, r_cx});
            r1_dy <= $signed({1'b0, N'(i_data.point_y)}) - $signed({1'b0, r_cy});
        end
    end

    // Stage 2: squares
    logic                    r2_v;
    logic signed [DXW-1:0]   r2_dx, r2_dy;
    logic [SQW-1:0]          r2_dx2, r2_dy2, r2_r2;
    logic signed [2*DXW-1:0] dx2_full, dy2_full;
    logic [2*N-1:0]          r2_full;

    assign dx2_full = r1_dx * r1_dx;
    assign dy2_full = r1_dy * r1_dy;
    assign r2_full  = r_rad * r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_dx2 <= dx2_full[SQW-1:0];
            r2_dy2 <= dy2_full[SQW-1:0];
            r2_r2  <= r2_full;
        end
    end

    // Stage 3: distance squared and the outside test
    logic                  r3_v;
    logic                  r3_ok;
    logic signed [DXW-1:0] r3_dx, r3_dy;
    logic [H2W-1:0]        r3_h2, r3_diff;
    logic [H2W-1:0]        h2_sum;
    logic                  ok3;

    assign h2_sum = H2W'(r2_dx2) + H2W'(r2_dy2);
    assign ok3    = h2_sum > H2W'(r2_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_h2   <= h2_sum;
            r3_ok   <= ok3;
            r3_diff <= ok3 ? h2_sum - H2W'(r2_r2) : '0;
        end
    end

    // Square root with eight fractional bits
    logic              sq_v;
    logic [SB-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;
    logic [RAD_W-1:0]  sq_rad;

    assign sq_rad = {1'b0, r3_diff, {(2 * FR){1'b0}}};

    ctp_sqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rad   (sq_rad),
        .i_side  ({r3_ok, r3_dx, r3_dy, r3_h2}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic                  sq_ok;
    logic signed [DXW-1:0] sq_dx, sq_dy;
    logic [H2W-1:0]        sq_h2;
    logic signed [SB:0]    s_s;

    assign {sq_ok, sq_dx, sq_dy, sq_h2} = sq_side;
    assign s_s = $signed({1'b0, sq_root});

    // Stage 4: products with radius and root
    logic                  r4_v;
    logic                  r4_ok;
    logic [H2W-1:0]        r4_h2;
    logic signed [RDW-1:0] r4_rdx, r4_rdy;
    logic signed [SDW-1:0] r4_sdx, r4_sdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ok  <= sq_ok;
            r4_h2  <= sq_h2;
            r4_rdx <= rad_s * sq_dx;
            r4_rdy <= rad_s * sq_dy;
            r4_sdx <= s_s * sq_dx;
            r4_sdy <= s_s * sq_dy;
        end
    end

    // Stage 5: the four numerators
    logic                   r5_v;
    logic                   r5_ok;
    logic [DENW-1:0]        r5_den;
    logic signed [NUMW-1:0] r5_num [NL];
    logic signed [NUMW-1:0] rdx_w, rdy_w, sdx_w, sdy_w;

    assign rdx_w = NUMW'($signed({r4_rdx, {FR{1'b0}}}));
    assign rdy_w = NUMW'($signed({r4_rdy, {FR{1'b0}}}));
    assign sdx_w = NUMW'(r4_sdx);
    assign sdy_w = NUMW'(r4_sdy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ok     <= r4_ok;
            r5_den    <= {r4_h2, {FR{1'b0}}};
            r5_num[0] <= rdx_w - sdy_w;
            r5_num[1] <= rdy_w + sdx_w;
            r5_num[2] <= rdx_w + sdy_w;
            r5_num[3] <= rdy_w - sdx_w;
        end
    end

    // Stage 6: scale by the radius, center times the denominator
    logic                  r6_v;
    logic                  r6_ok;
    logic [DENW-1:0]       r6_den;
    logic signed [RNW-1:0] r6_rn [NL];
    logic [CDW-1:0]        r6_cxd, r6_cyd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ok  <= r5_ok;
            r6_den <= r5_den;
            r6_cxd <= r_cx * r5_den;
            r6_cyd <= r_cy * r5_den;
            for (int l = 0; l < NL; l++) begin
                r6_rn[l] <= rad_s * r5_num[l];
            end
        end
    end

    // Stage 7: full dividends
    logic                   r7_v;
    logic                   r7_ok;
    logic [DENW-1:0]        r7_den;
    logic signed [TOTW-1:0] r7_tot [NL];
    logic signed [TOTW-1:0] cxd_w, cyd_w;

    assign cxd_w = TOTW'($signed({1'b0, r6_cxd}));
    assign cyd_w = TOTW'($signed({1'b0, r6_cyd}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ok     <= r6_ok;
            r7_den    <= r6_den;
            r7_tot[0] <= cxd_w + TOTW'(r6_rn[0]);
            r7_tot[1] <= cyd_w + TOTW'(r6_rn[1]);
            r7_tot[2] <= cxd_w + TOTW'(r6_rn[2]);
            r7_tot[3] <= cyd_w + TOTW'(r6_rn[3]);
        end
    end

    // Stage 8: sign and magnitude, so the divider truncates toward zero
    logic                        r8_v;
    logic                        r8_ok;
    logic [DENW-1:0]             r8_den;
    logic [NL-1:0]               r8_neg;
    logic [NL-1:0][TOTW-1:0]     r8_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_ok  <= r7_ok;
            r8_den <= r7_den;
            for (int l = 0; l < NL; l++) begin
                r8_neg[l] <= r7_tot[l][TOTW-1];
                r8_mag[l] <= r7_tot[l][TOTW-1] ? TOTW'(-r7_tot[l]) : TOTW'(r7_tot[l]);
            end
        end
    end

    // Division
    logic                  dv_v;
    logic [NL-1:0][QB-1:0] dv_quo;
    logic [NL:0]           dv_side;

    ctp_div #(
        .MAG_W  (TOTW),
        .DEN_W  (DENW),
        .Q_B    (QB),
        .SIDE_W (NL + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_v),
        .i_mag   (r8_mag),
        .i_den   (r8_den),
        .i_side  ({r8_ok, r8_neg}),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Output register
    ctp_pkg::t_out         r_out;
    ctp_pkg::t_out         n_out;
    logic signed [QVW-1:0] qv [NL];
    logic [OW-1:0]         co [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            qv[l] = $signed(QVW'(dv_quo[l]));
            if (dv_side[l]) begin
                qv[l] = -qv[l];
            end
            co[l] = dv_side[NL] ? qv[l][OW-1:0] : '0;
        end
        n_out.valid_res = dv_side[NL];
        n_out.tan1_x    = $signed(co[0]);
        n_out.tan1_y    = $signed(co[1]);
        n_out.tan2_x    = $signed(co[2]);
        n_out.tan2_y    = $signed(co[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ----- verif/tb_circle_tangent_points.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_circle_tangent_points;

    localparam int LATENCY   = 40;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    ctp_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    ctp_pkg::t_out o_data;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [ctp_pkg::CFG_W-1:0] i_cfg_data = '0;

    int n_errors = 0;
    int n_points = 0;
    int n_outside = 0;
    int cycle = 0;
    bit quiet = 0;

    circle_tangent_points dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report(input string what, input int got, input int want);
        n_errors++;
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle);
    endtask

    class tangent_scoreboard;
        logic [9:0] cx = 10'(ctp_pkg::CENTER_X_RESET);
        logic [9:0] cy = 10'(ctp_pkg::CENTER_Y_RESET);
        logic [9:0] rad = 10'(ctp_pkg::RADIUS_RESET);
        ctp_pkg::t_out pending[$];

        function automatic logic [11:0] solve_coord(longint c, longint num, longint h2);
            longint den;
            longint q;
            den = h2 * 256;
            q = (c * den + longint'(rad) * num) / den;
            return q[11:0];
        endfunction

        function automatic longint root(longint v);
            longint lo, hi, mid;
            lo = 0;
            hi = 64'd1 << 32;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (mid * mid <= v) lo = mid;
                else hi = mid;
            end
            return lo;
        endfunction

        function void note_point(ctp_pkg::t_in p);
            ctp_pkg::t_out e;
            longint dx, dy, h2, r, s8, rx, ry;
            e = '0;
            r = longint'(rad);
            dx = longint'(p.point_x) - longint'(cx);
            dy = longint'(p.point_y) - longint'(cy);
            h2 = dx * dx + dy * dy;
            if (h2 > r * r) begin
                s8 = root((h2 - r * r) * 65536);
                rx = r * 256 * dx;
                ry = r * 256 * dy;
                e.valid_res = 1'b1;
                e.tan1_x = solve_coord(longint'(cx), rx - s8 * dy, h2);
                e.tan1_y = solve_coord(longint'(cy), ry + s8 * dx, h2);
                e.tan2_x = solve_coord(longint'(cx), rx + s8 * dy, h2);
                e.tan2_y = solve_coord(longint'(cy), ry - s8 * dx, h2);
            end
            pending.push_back(e);
        endfunction

        task check_result(ctp_pkg::t_out got);
            ctp_pkg::t_out e;
            if (pending.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                e = pending.pop_front();
                if (got.valid_res !== e.valid_res)
                    report("valid_res", int'(got.valid_res), int'(e.valid_res));
                if (got.tan1_x !== e.tan1_x) report("tan1_x", int'(got.tan1_x), int'(e.tan1_x));
                if (got.tan1_y !== e.tan1_y) report("tan1_y", int'(got.tan1_y), int'(e.tan1_y));
                if (got.tan2_x !== e.tan2_x) report("tan2_x", int'(got.tan2_x), int'(e.tan2_x));
                if (got.tan2_y !== e.tan2_y) report("tan2_y", int'(got.tan2_y), int'(e.tan2_y));
            end
        endtask
    endclass

    tangent_scoreboard sb = new();

    // Monitor both channels at the rising edge.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("Timeout at cycle %0d", cycle);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_point(i_data);
                n_points++;
                if (sb.pending[$].valid_res) n_outside++;
            end
            if (o_valid && !i_stall) sb.check_result(o_data);
        end
    end

    // Receiver stalls in random bursts.
    initial begin
        int k;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 7);
                i_stall <= 1'b1;
                repeat (k) @(negedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(input ctp_pkg::t_cfg_idx idx, input logic [9:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ctp_pkg::CFG_CENTER_X: sb.cx = val;
            ctp_pkg::CFG_CENTER_Y: sb.cy = val;
            default: sb.rad = val;
        endcase
    endtask

    task automatic set_circle(input logic [9:0] x, input logic [9:0] y, input logic [9:0] r);
        write_reg(ctp_pkg::CFG_CENTER_X, x);
        write_reg(ctp_pkg::CFG_CENTER_Y, y);
        write_reg(ctp_pkg::CFG_RADIUS, r);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send_point(input logic [9:0] x, input logic [9:0] y);
        int k;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            k = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (k) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{point_x: x, point_y: y};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Called at the falling edge right after the last accepted point.
    task automatic finish_phase();
        i_valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic random_points(input int n);
        logic [9:0] x, y;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: begin
                    x = 10'($urandom);
                    y = 10'($urandom);
                end
                1: begin
                    // Near the circle edge, both sides.
                    x = 10'(sb.cx + $urandom_range(0, 2 * sb.rad + 4) - sb.rad - 2);
                    y = 10'(sb.cy + $urandom_range(0, 2 * sb.rad + 4) - sb.rad - 2);
                end
                2: begin
                    x = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
                    y = 10'($urandom);
                end
                default: begin
                    x = 10'(sb.cx + $urandom_range(0, 40) - 20);
                    y = 10'($urandom);
                end
            endcase
            send_point(x, y);
        end
    endtask

    initial begin
        logic [9:0] cxs[6] = '{10'd400, 10'd0, 10'd1023, 10'd512, 10'd0, 10'd1023};
        logic [9:0] cys[6] = '{10'd300, 10'd0, 10'd1023, 10'd512, 10'd1023, 10'd0};
        logic [9:0] rs[6]  = '{10'd100, 10'd1, 10'd1023, 10'd0, 10'd300, 10'd37};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset circle, edge, center, inside, far corners.
        send_point(10'd400, 10'd300);
        send_point(10'd500, 10'd300);
        send_point(10'd501, 10'd300);
        send_point(10'd400, 10'd199);
        send_point(10'd450, 10'd320);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'h2AA, 10'h155);
        send_point(10'h155, 10'h2AA);
        finish_phase();
        set_circle(10'd1023, 10'd1023, 10'd1023);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd0);
        send_point(10'd0, 10'd1023);
        send_point(10'd1023, 10'd1023);
        finish_phase();
        set_circle(10'd512, 10'd512, 10'd0);
        send_point(10'd512, 10'd512);
        send_point(10'd513, 10'd512);
        send_point(10'd0, 10'd0);
        finish_phase();

        for (int ph = 0; ph < 6; ph++) begin
            set_circle(cxs[ph], cys[ph], rs[ph]);
            if (ph == 5) quiet = 1;
            random_points(310);
            finish_phase();
        end

        $display("Covered %0d points (%0d outside the circle) over 9 circle settings.",
                 n_points, n_outside);
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
rtl/ctp_pkg.sv
rtl/ctp_sqrt.sv
rtl/ctp_div.sv
rtl/circle_tangent_points.sv
verif/tb_circle_tangent_points.sv
